@@ rtl/polyev_pkg.sv @@
// ----------------------------------------------------------------------------
// polyev_pkg
// shared types and constants for the polynomial evaluator
// ----------------------------------------------------------------------------
package polyev_pkg;

  // width of values, coefficients and results (signed fixed point)
  localparam int unsigned DataW = 32;

  // configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DegW    = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDegree = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoef0  = 3'd1;

  typedef logic signed [DataW-1:0] data_t;

  // saturation limits
  localparam data_t DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataW-1){1'b0}}};

endpackage

@@ rtl/polyev_mac.sv @@
// ----------------------------------------------------------------------------
// polyev_mac
// shared horner step unit: registered multiply, then shift, add and saturate
// ----------------------------------------------------------------------------
module polyev_mac import polyev_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  mul_en_i,
  input  data_t acc_i,
  input  data_t x_i,
  input  data_t coef_i,
  output data_t res_o,
  output logic  sat_o
);

  localparam int unsigned ProdW = 2 * DataW;

  logic signed [ProdW-1:0]     prod_q;
  logic signed [ProdW-1:0]     prod_d;
  logic signed [ProdW-1:0]     shifted;
  logic signed [ProdW:0]       sum;
  logic [ProdW-DataW+1:0]      upper;

  assign prod_d = ProdW'(acc_i) * ProdW'(x_i);

  // product register, only loaded on the multiply cycle
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod_q >>> FRAC_BITS;
  assign sum     = {shifted[ProdW-1], shifted} + {{(ProdW-DataW+1){coef_i[DataW-1]}}, coef_i};
  assign upper   = sum[ProdW:DataW-1];

  // in range only when every bit above the result sign matches it
  assign sat_o = !((upper == '0) || (upper == '1));

  always_comb begin
    if (!sat_o) begin
      res_o = sum[DataW-1:0];
    end else if (sum[ProdW]) begin
      res_o = DataMin;
    end else begin
      res_o = DataMax;
    end
  end

endmodule

@@ rtl/polynomial_evaluator.sv @@
// ----------------------------------------------------------------------------
// polynomial_evaluator
// signed fixed-point polynomial evaluation by horner's rule on one shared
// multiply-add unit, with per-step saturation and a sticky overflow flag
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction  transfer when
//  -------   -----------------------------------  ---------  ------------------
//  command   start_i, busy_o, x_value_i           in         start_i & !busy_o
//  result    done_o, y_value_o, overflow_o        out        done_o (one cycle)
//  config    cfg_we_i, cfg_idx_i, cfg_data_i      in         cfg_we_i
//
//  an item with degree d (clamped to MAX_DEGREE) runs d horner steps between
//  the command transfer and the done_o cycle; every horner step passes through
//  StMul in the shared multiplier and then StAdd in the shift/add/saturate path
//  a new command is taken the cycle after done_o, so items never overlap
//  reset clears the sequencer, the degree and all coefficients at once
//  the receiver cannot stall: the result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module polynomial_evaluator import polyev_pkg::*; #(
  parameter int unsigned MAX_DEGREE = 6,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command
  input  logic               start_i,
  output logic               busy_o,
  input  data_t              x_value_i,
  // result
  output logic               done_o,
  output data_t              y_value_o,
  output logic               overflow_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned NumCoef = MAX_DEGREE + 1;
  localparam int unsigned StepW   = (NumCoef > 1) ? $clog2(NumCoef) : 1;

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  data_t            acc_q, acc_d;
  data_t            x_q, x_d;
  logic             ovf_q, ovf_d;

  logic [DegW-1:0]  degree_q;
  data_t            coef_q [NumCoef];

  logic             accept;
  logic [StepW-1:0] deg_sel;
  logic [StepW-1:0] rd_idx;
  data_t            coef_rd;
  data_t            mac_res;
  logic             mac_sat;

  // command transfer
  assign accept = start_i && (state_q == StIdle);

  // degrees past the top coefficient fall back to the top one
  assign deg_sel = (degree_q > DegW'(MAX_DEGREE)) ? StepW'(MAX_DEGREE)
                                                  : StepW'(degree_q);

  // one coefficient read port: top coefficient at the transfer, next one down
  // while stepping
  assign rd_idx  = (state_q == StIdle) ? deg_sel : (step_q - StepW'(1));
  assign coef_rd = coef_q[rd_idx];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == RegDegree)) begin
      degree_q <= cfg_data_i[DegW-1:0];
    end
  end

  // coefficients past MAX_DEGREE are never used, so their writes are dropped
  for (genvar k = 0; k < NumCoef; k++) begin : g_coef
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_q[k] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == RegCoef0 + CfgIdxW'(k))) begin
        coef_q[k] <= cfg_data_i;
      end
    end
  end

  polyev_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .mul_en_i (state_q == StMul),
    .acc_i    (acc_q),
    .x_i      (x_q),
    .coef_i   (coef_rd),
    .res_o    (mac_res),
    .sat_o    (mac_sat)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    acc_d   = acc_q;
    x_d     = x_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          acc_d   = coef_rd;
          x_d     = x_value_i;
          step_d  = deg_sel;
          ovf_d   = 1'b0;
          // degree zero gives the constant term directly
          state_d = (deg_sel == '0) ? StOut : StMul;
        end
      end
      StMul: begin
        state_d = StAdd;
      end
      StAdd: begin
        acc_d   = mac_res;
        ovf_d   = ovf_q | mac_sat;
        step_d  = step_q - StepW'(1);
        state_d = (step_q == StepW'(1)) ? StOut : StMul;
      end
      StOut: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // datapath registers need no reset
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    ovf_q <= ovf_d;
  end

  // outputs straight from registers
  assign busy_o     = (state_q != StIdle);
  assign done_o     = (state_q == StOut);
  assign y_value_o  = acc_q;
  assign overflow_o = ovf_q;

endmodule
